>>> rtl/gltok_pkg.sv
// Shared types, codes and constants of the longest-match tokenizer.
package gltok_pkg;

  localparam int unsigned DEF_NUM_ENTRIES = 1024;
  localparam int unsigned DEF_MAX_LEN     = 16;
  localparam int unsigned SCAN_CAP        = 100000;

  localparam logic [7:0] MARK_B0    = 8'hE2;
  localparam logic [7:0] MARK_B1    = 8'h96;
  localparam logic [7:0] MARK_B2    = 8'h81;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [1:0] {
    OP_VOCAB_BYTE = 2'd0,
    OP_ENTRY_LEN  = 2'd1,
    OP_TEXT_BYTE  = 2'd2,
    OP_DECODE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_BYTE  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_VOCAB_COUNT = 1'b0,
    CFG_TOKEN_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_APPLY,
    ST_COUNT,
    ST_DLEN,
    ST_DEMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr;
    logic scan_start;
    logic scan;
    logic apply;
    logic emit_cnt;
    logic dec_start;
    logic dec_emit;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic fin;
    logic fill_full;
    logic fill_nz;
    logic below_limit;
    logic scan_done;
    logic has_match;
    logic clr_done;
    logic out_free;
    logic dec_empty;
    logic dec_last;
  } sts_t;

endpackage

>>> rtl/greedy_longest_match_tokenizer_core.sv
// Top level of the greedy longest-match tokenizer.
// Sequence: a token decision checks the window, scans min(vocab_count, NUM_ENTRIES) rows, one
// row read per cycle, and applies the best match; a decode reads its entry, then emits items;
// end of text repeats decisions until the window drains or the token limit is reached.
// Throughput: one item at a time; an item may be accepted while a result waits to be taken.
// Reset: synchronous, active low, then a clearing pass sets every entry length to zero.
module greedy_longest_match_tokenizer_core #(
  parameter int unsigned NUM_ENTRIES = gltok_pkg::DEF_NUM_ENTRIES,
  parameter int unsigned MAX_LEN     = gltok_pkg::DEF_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_entry_index,
  input  logic [3:0]  in_char_position,
  input  logic [7:0]  in_byte_value,
  input  logic [4:0]  in_entry_length,
  input  logic [15:0] in_decode_id,
  input  logic        in_final_item,
  // configuration writes, also taken during the clearing pass
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [9:0]  out_match_id,
  output logic [7:0]  out_out_byte,
  output logic [15:0] out_token_count,
  output logic        out_last_result
);

  // Command and status between the sequencer and the datapath.
  gltok_pkg::cmd_t cmd;
  gltok_pkg::sts_t sts;

  // The sequencer holds input in every state but idle, steps the scan, and
  // advances the decode emission only when the result register is free.
  gltok_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // The datapath owns the vocabulary memories, the window, the best-match
  // registers and the result register that parts the output side.
  gltok_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_char_position (in_char_position),
    .in_byte_value    (in_byte_value),
    .in_entry_length  (in_entry_length),
    .in_decode_id     (in_decode_id),
    .in_final_item    (in_final_item),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_match_id     (out_match_id),
    .out_out_byte     (out_out_byte),
    .out_token_count  (out_token_count),
    .out_last_result  (out_last_result)
  );

endmodule

>>> rtl/gltok_ctrl.sv
// Sequencing state machine of the tokenizer.
module gltok_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  gltok_pkg::sts_t sts,
  output gltok_pkg::cmd_t cmd,
  output logic            in_stall
);

  gltok_pkg::state_t state_r, state_nxt;
  logic go_scan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gltok_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    if (!sts.fin) begin
      go_scan = sts.fill_full && sts.below_limit;
    end else begin
      go_scan = sts.fill_nz && sts.below_limit;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gltok_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = gltok_pkg::ST_IDLE;
      end
      gltok_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_op == gltok_pkg::OP_TEXT_BYTE) state_nxt = gltok_pkg::ST_CHECK;
          else if (sts.in_op == gltok_pkg::OP_DECODE) state_nxt = gltok_pkg::ST_DLEN;
        end
      end
      gltok_pkg::ST_CHECK: begin
        if (go_scan) state_nxt = gltok_pkg::ST_SCAN;
        else if (sts.fin) state_nxt = gltok_pkg::ST_COUNT;
        else state_nxt = gltok_pkg::ST_IDLE;
      end
      gltok_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = gltok_pkg::ST_APPLY;
      end
      gltok_pkg::ST_APPLY: begin
        if (!sts.has_match || sts.out_free) begin
          state_nxt = sts.fin ? gltok_pkg::ST_CHECK : gltok_pkg::ST_IDLE;
        end
      end
      gltok_pkg::ST_COUNT: begin
        if (sts.out_free) state_nxt = gltok_pkg::ST_IDLE;
      end
      gltok_pkg::ST_DLEN: begin
        state_nxt = gltok_pkg::ST_DEMIT;
      end
      gltok_pkg::ST_DEMIT: begin
        if (sts.out_free && (sts.dec_empty || sts.dec_last)) state_nxt = gltok_pkg::ST_IDLE;
      end
      default: state_nxt = gltok_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == gltok_pkg::ST_IDLE) && in_valid;
    cmd.clr        = (state_r == gltok_pkg::ST_CLEAR);
    cmd.scan_start = (state_r == gltok_pkg::ST_CHECK) && go_scan;
    cmd.scan       = (state_r == gltok_pkg::ST_SCAN);
    cmd.apply      = (state_r == gltok_pkg::ST_APPLY) && (!sts.has_match || sts.out_free);
    cmd.emit_cnt   = (state_r == gltok_pkg::ST_COUNT) && sts.out_free;
    cmd.dec_start  = (state_r == gltok_pkg::ST_DLEN);
    cmd.dec_emit   = (state_r == gltok_pkg::ST_DEMIT) && sts.out_free;
  end

  assign in_stall = (state_r != gltok_pkg::ST_IDLE);

endmodule

>>> rtl/gltok_datapath.sv
// Vocabulary memories, lookahead window, match scan and result register.
module gltok_datapath #(
  parameter int unsigned NUM_ENTRIES = gltok_pkg::DEF_NUM_ENTRIES,
  parameter int unsigned MAX_LEN     = gltok_pkg::DEF_MAX_LEN
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gltok_pkg::cmd_t cmd,
  output gltok_pkg::sts_t sts,
  input  logic [1:0]      in_operation,
  input  logic [9:0]      in_entry_index,
  input  logic [3:0]      in_char_position,
  input  logic [7:0]      in_byte_value,
  input  logic [4:0]      in_entry_length,
  input  logic [15:0]     in_decode_id,
  input  logic            in_final_item,
  input  logic            cfg_wr_en,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_wdata,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_result_kind,
  output logic [9:0]      out_match_id,
  output logic [7:0]      out_out_byte,
  output logic [15:0]     out_token_count,
  output logic            out_last_result
);

  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // configuration
  logic [10:0] vocab_count_r;
  logic [15:0] token_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_count_r <= '0;
      token_limit_r <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      unique case (gltok_pkg::cfg_idx_t'(cfg_index))
        gltok_pkg::CFG_VOCAB_COUNT: vocab_count_r <= cfg_wdata[10:0];
        gltok_pkg::CFG_TOKEN_LIMIT: token_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input decode
  gltok_pkg::op_t op;
  logic [31:0]    idx32, did32, n32;
  logic           idx_ok, pos_ok, dec_ok;
  logic [AW-1:0]  waddr;
  logic [PW-1:0]  wpos;
  logic [LW-1:0]  len_sat;
  logic [CW-1:0]  n_lim;

  assign op      = gltok_pkg::op_t'(in_operation);
  assign idx32   = 32'(in_entry_index);
  assign did32   = 32'(in_decode_id);
  assign idx_ok  = idx32 < NUM_ENTRIES;
  assign pos_ok  = 32'(in_char_position) < MAX_LEN;
  assign waddr   = idx32[AW-1:0];
  assign wpos    = PW'(in_char_position);
  assign len_sat = (32'(in_entry_length) > MAX_LEN) ? LW'(MAX_LEN) : LW'(in_entry_length);
  assign dec_ok  = (did32 < 32'(vocab_count_r)) && (did32 < NUM_ENTRIES);

  always_comb begin
    n32 = (32'(vocab_count_r) < NUM_ENTRIES) ? 32'(vocab_count_r) : NUM_ENTRIES;
    if (n32 > gltok_pkg::SCAN_CAP) n32 = gltok_pkg::SCAN_CAP;
  end
  assign n_lim = CW'(n32);

  // shared sweep counter: clearing pass after reset, then entry scans
  logic [CW-1:0] cnt_r;
  logic          cnt_live, clr_done;

  assign cnt_live = cnt_r < n_lim;
  assign clr_done = cnt_r == CW'(NUM_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.scan_start) begin
      cnt_r <= '0;
    end else if ((cmd.clr && !clr_done) || (cmd.scan && cnt_live)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // memories
  logic [MAX_LEN-1:0][7:0] vmem [NUM_ENTRIES];
  logic [LW-1:0]           lmem [NUM_ENTRIES];
  logic [MAX_LEN-1:0][7:0] row_q;
  logic [LW-1:0]           len_q;
  logic                    rd_fire;
  logic [AW-1:0]           raddr;

  assign rd_fire = (cmd.scan && cnt_live) || (cmd.accept && op == gltok_pkg::OP_DECODE);
  assign raddr   = cmd.scan ? cnt_r[AW-1:0] : did32[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && op == gltok_pkg::OP_VOCAB_BYTE && idx_ok && pos_ok) begin
      vmem[waddr][wpos] <= in_byte_value;
    end
    if (rd_fire) row_q <= vmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && !clr_done) begin
      lmem[cnt_r[AW-1:0]] <= '0;
    end else if (cmd.accept && op == gltok_pkg::OP_ENTRY_LEN && idx_ok) begin
      lmem[waddr] <= len_sat;
    end
    if (rd_fire) len_q <= lmem[raddr];
  end

  // effective length: cut at the first zero byte
  logic [LW-1:0] el;
  always_comb begin
    el = len_q;
    for (int k = MAX_LEN - 1; k >= 0; k--) begin
      if (LW'(k) < len_q && row_q[k] == 8'h00) el = LW'(k);
    end
  end

  // window and scan state
  logic [7:0]    win_r [MAX_LEN];
  logic [7:0]    win_nxt [MAX_LEN];
  logic [LW-1:0] fill_r;
  logic [15:0]   emitted_r;
  logic          fin_r;
  logic          p_v_r;
  logic [AW-1:0] p_id_r;
  logic [LW-1:0] longest_r;
  logic [AW-1:0] best_id_r;
  logic          mism, cand, below, has_match;
  logic [LW-1:0] used;

  assign below     = emitted_r < token_limit_r;
  assign has_match = longest_r != '0;
  assign used      = has_match ? longest_r : LW'(1);

  always_comb begin
    mism = 1'b0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (LW'(k) < el && row_q[k] != win_r[k]) mism = 1'b1;
    end
  end
  assign cand = p_v_r && (el != '0) && (el <= fill_r) && (el > longest_r) && !mism;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= cmd.scan && cnt_live;
    end
  end

  always_ff @(posedge clk) begin
    p_id_r <= cnt_r[AW-1:0];
    if (cmd.scan_start) begin
      longest_r <= '0;
      best_id_r <= '0;
    end else if (cand) begin
      longest_r <= el;
      best_id_r <= p_id_r;
    end
  end

  always_comb begin
    logic [LW:0] s;
    for (int k = 0; k < MAX_LEN; k++) begin
      s = (LW + 1)'(k) + {1'b0, used};
      win_nxt[k] = (s < (LW + 1)'(MAX_LEN)) ? win_r[s[PW-1:0]] : win_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && op == gltok_pkg::OP_TEXT_BYTE && below && fill_r < LW'(MAX_LEN)) begin
      win_r[fill_r[PW-1:0]] <= in_byte_value;
    end else if (cmd.apply) begin
      win_r <= win_nxt;
    end
    if (cmd.accept) fin_r <= in_final_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      emitted_r <= '0;
    end else if (cmd.emit_cnt) begin
      fill_r    <= '0;
      emitted_r <= '0;
    end else if (cmd.accept && op == gltok_pkg::OP_TEXT_BYTE && below &&
                 fill_r < LW'(MAX_LEN)) begin
      fill_r <= fill_r + 1'b1;
    end else if (cmd.apply) begin
      fill_r <= fill_r - used;
      if (has_match) emitted_r <= emitted_r + 1'b1;
    end
  end

  // decode
  logic          dec_ok_r, sp_r, marker, dec_last;
  logic [LW-1:0] dec_el_r, j_r;

  assign marker = (el >= LW'(3)) && row_q[0] == gltok_pkg::MARK_B0 &&
                  row_q[PW'(1 % MAX_LEN)] == gltok_pkg::MARK_B1 &&
                  row_q[PW'(2 % MAX_LEN)] == gltok_pkg::MARK_B2;
  assign dec_last = sp_r ? (dec_el_r == LW'(3)) : ({1'b0, j_r} + 1'b1 == {1'b0, dec_el_r});

  always_ff @(posedge clk) begin
    if (cmd.accept) dec_ok_r <= dec_ok;
    if (cmd.dec_start) begin
      dec_el_r <= dec_ok_r ? el : '0;
      sp_r     <= dec_ok_r && marker;
      j_r      <= (dec_ok_r && marker) ? LW'(3) : '0;
    end else if (cmd.dec_emit && dec_el_r != '0) begin
      if (sp_r) sp_r <= 1'b0;
      else j_r <= j_r + 1'b1;
    end
  end

  // result register
  logic        out_valid_r, emit_any, out_free;
  logic [1:0]  kind_r;
  logic [9:0]  tid_r;
  logic [7:0]  byte_r;
  logic [15:0] count_r;
  logic        last_r;
  logic [31:0] bid32;

  assign bid32    = 32'(best_id_r);
  assign emit_any = (cmd.apply && has_match) || cmd.emit_cnt || cmd.dec_emit;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) begin
      tid_r   <= '0;
      byte_r  <= '0;
      count_r <= '0;
      if (cmd.apply) begin
        kind_r <= gltok_pkg::KIND_TOKEN;
        tid_r  <= bid32[9:0];
        last_r <= !fin_r;
      end else if (cmd.emit_cnt) begin
        kind_r  <= gltok_pkg::KIND_COUNT;
        count_r <= emitted_r;
        last_r  <= 1'b1;
      end else if (dec_el_r == '0) begin
        kind_r <= gltok_pkg::KIND_EMPTY;
        last_r <= 1'b1;
      end else begin
        kind_r <= gltok_pkg::KIND_BYTE;
        byte_r <= sp_r ? gltok_pkg::SPACE_BYTE : row_q[j_r[PW-1:0]];
        last_r <= dec_last;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_match_id    = tid_r;
  assign out_out_byte    = byte_r;
  assign out_token_count = count_r;
  assign out_last_result = last_r;

  always_comb begin
    sts             = '0;
    sts.in_op       = op;
    sts.fin         = fin_r;
    sts.fill_full   = fill_r == LW'(MAX_LEN);
    sts.fill_nz     = fill_r != '0;
    sts.below_limit = below;
    sts.scan_done   = !cnt_live && !p_v_r;
    sts.has_match   = has_match;
    sts.clr_done    = clr_done;
    sts.out_free    = out_free;
    sts.dec_empty   = dec_el_r == '0;
    sts.dec_last    = dec_last;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(MAX_LEN)) else $error("window fill beyond capacity");

  a_apply_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> fill_r != '0) else $error("decision on empty window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> !(out_valid_r && out_stall)) else $error("result register overwritten");

  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_cnt |=> (fill_r == '0 && emitted_r == '0)) else $error("text state not cleared");

endmodule
